FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// every macro expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TCSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define TCSB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/tcsb_pkg.sv
// shared types and constants of the text console scroll buffer
// no dependencies
`default_nettype none

package tcsb_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] reg_idx_t;

  // geometry defaults
  localparam int DEF_CHARS_PER_LINE = 40;
  localparam int DEF_LINE_COUNT     = 30;
  localparam int DEF_CELL_COUNT     = 1200;

  // operation codes of an input item
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // character codes
  localparam byte_t CODE_CR    = 8'h0D;
  localparam byte_t CODE_LF    = 8'h0A;
  localparam byte_t CODE_SPACE = 8'h20;
  localparam byte_t CODE_ZERO  = 8'h00;

  // configuration register indexes
  localparam reg_idx_t REG_CURSOR_DIR   = 2'd0;
  localparam reg_idx_t REG_CURSOR_WRITE = 2'd1;
  localparam reg_idx_t REG_MEMORY_WRITE = 2'd2;

  // configuration reset values
  localparam byte_t RST_CURSOR_DIR   = 8'h4C;
  localparam byte_t RST_CURSOR_WRITE = 8'd70;
  localparam byte_t RST_MEMORY_WRITE = 8'd66;

  // refresh sequence positions before the cell bytes
  localparam int POS_DIR_CMD  = 0;
  localparam int POS_ADDR_CMD = 1;
  localparam int POS_ADDR_LO  = 2;
  localparam int POS_ADDR_HI  = 3;
  localparam int POS_MEM_CMD  = 4;
  localparam int SEQ_HEAD     = 5;

endpackage

`default_nettype wire

FILE: hw/rtl/tcsb_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module tcsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1200
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_scroll_buffer_top.sv
// Text console scroll buffer: a character grid of LINE_COUNT lines of CHARS_PER_LINE
// cells held in one ram, with a write cursor, scrolling and a refresh byte stream.
// A stored character passes through the idle and store states, carriage return and a
// plain line feed are handled in the idle state; a scroll walks the grid with one shared
// address counter and one ram port pair (move, fill, scroll end, then store if a
// character waits), and input stalls meanwhile. A drain tick loads a command byte
// directly and a cell byte through the read state (registered ram read); input also
// waits while a result item is held. After reset a clearing pass writes zero to all
// CELL_COUNT cells, one per cycle, before the first item.
// Depends on tcsb_pkg, tcsb_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module text_console_scroll_buffer_top #(
  parameter int CHARS_PER_LINE = tcsb_pkg::DEF_CHARS_PER_LINE,
  parameter int LINE_COUNT     = tcsb_pkg::DEF_LINE_COUNT,
  parameter int CELL_COUNT     = tcsb_pkg::DEF_CELL_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire tcsb_pkg::reg_idx_t cfg_index,
  input  wire tcsb_pkg::byte_t   cfg_data,
  // input items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire tcsb_pkg::byte_t   char_code,
  input  wire logic              last_of_write,
  // result items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   lcd_is_command,
  output tcsb_pkg::byte_t        lcd_byte,
  output logic                   refresh_done
);

  import tcsb_pkg::*;

  localparam int LAST_START = (LINE_COUNT - 1) * CHARS_PER_LINE;
  localparam int CUR_MAX    = (CELL_COUNT > LAST_START) ? CELL_COUNT : LAST_START + 1;
  localparam int CUR_W      = $clog2(CUR_MAX + 1);
  localparam int LINE_MAX   = (CUR_MAX / CHARS_PER_LINE > LINE_COUNT - 1) ?
                              CUR_MAX / CHARS_PER_LINE : LINE_COUNT - 1;
  localparam int LINE_W     = $clog2(LINE_MAX + 1);
  localparam int COL_W      = $clog2(CHARS_PER_LINE);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int POS_W      = $clog2(CELL_COUNT + SEQ_HEAD + 1);
  localparam int MOVE_N     = (CELL_COUNT > CHARS_PER_LINE) ? CELL_COUNT - CHARS_PER_LINE : 0;
  localparam bit HAS_FILL   = LAST_START < CELL_COUNT;
  localparam int FILL_LO    = HAS_FILL ? LAST_START : 0;
  localparam int FILL_END   = (LAST_START + CHARS_PER_LINE < CELL_COUNT) ?
                              LAST_START + CHARS_PER_LINE : CELL_COUNT;
  localparam int FILL_LAST  = HAS_FILL ? FILL_END - 1 : 0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_STORE,
    S_MOVE,
    S_FILL,
    S_SCROLL_END
  } state_t;

  state_t state;

  // configuration registers
  byte_t cursor_dir_cmd;
  byte_t cursor_write_cmd;
  byte_t memory_write_cmd;

  // cursor and write bookkeeping
  logic [CUR_W-1:0]  cursor;
  logic [LINE_W-1:0] line;
  logic [COL_W-1:0]  col;
  logic [CUR_W-1:0]  wstart;
  logic [CNT_W-1:0]  wcount;
  logic              pending;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  rlen;
  logic              store_pend;
  byte_t             ch;

  // shared sweep counter for clearing, moving and filling
  logic [CNT_W-1:0]  idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  byte_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  byte_t             ram_rdata;

  logic              in_fire;
  logic              out_load;
  logic [CUR_W-1:0]  start_eff;
  logic [CNT_W-1:0]  count_next;
  logic [CUR_W:0]    end_sum;
  logic [CNT_W-1:0]  len_new;
  logic [POS_W:0]    pos_inc;
  logic [POS_W:0]    seq_end;
  logic              seq_last;
  logic [POS_W-1:0]  cell_pos;
  logic [CNT_W-1:0]  move_src;
  logic              head_cmd;
  byte_t             head_byte;
  state_t            scroll_state;
  logic [CNT_W-1:0]  scroll_idx;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);
  assign in_fire  = in_valid && in_ready;

  // a result item is loaded for a head byte now or for a cell byte after its read
  assign out_load = (state == S_READ) ||
                    (in_fire && operation == OP_DRAIN && pending && pos < POS_W'(SEQ_HEAD));

  // write span bookkeeping
  always_comb begin
    start_eff  = (wcount == '0) ? cursor : wstart;
    count_next = (wcount < CNT_W'(CELL_COUNT)) ? wcount + CNT_W'(1) : wcount;
    end_sum    = (CUR_W+1)'(start_eff) + (CUR_W+1)'(count_next);
    len_new    = (end_sum < (CUR_W+1)'(CELL_COUNT)) ? end_sum[CNT_W-1:0] : CNT_W'(CELL_COUNT);
  end

  // refresh sequence position
  always_comb begin
    pos_inc  = (POS_W+1)'(pos) + (POS_W+1)'(1);
    seq_end  = (POS_W+1)'(rlen) + (POS_W+1)'(SEQ_HEAD);
    seq_last = pos_inc >= seq_end;
    cell_pos = pos - POS_W'(SEQ_HEAD);
    move_src = idx + CNT_W'(CHARS_PER_LINE);
  end

  always_comb begin
    head_cmd  = 1'b1;
    head_byte = memory_write_cmd;
    priority if (pos == POS_W'(POS_DIR_CMD)) begin
      head_byte = cursor_dir_cmd;
    end else if (pos == POS_W'(POS_ADDR_CMD)) begin
      head_byte = cursor_write_cmd;
    end else if (pos == POS_W'(POS_ADDR_LO) || pos == POS_W'(POS_ADDR_HI)) begin
      head_cmd  = 1'b0;
      head_byte = CODE_ZERO;
    end else begin
      head_byte = memory_write_cmd;
    end
  end

  // first step of a scroll
  always_comb begin
    if (MOVE_N > 0) begin
      scroll_state = S_MOVE;
      scroll_idx   = '0;
    end else if (HAS_FILL) begin
      scroll_state = S_FILL;
      scroll_idx   = CNT_W'(FILL_LO);
    end else begin
      scroll_state = S_SCROLL_END;
      scroll_idx   = '0;
    end
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = CODE_SPACE;
    ram_raddr = cell_pos[ADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = CODE_ZERO;
      end
      S_MOVE: begin
        // read one line below, write the cell read last cycle
        ram_we    = idx != '0;
        ram_waddr = ADDR_W'(idx - CNT_W'(1));
        ram_wdata = ram_rdata;
        ram_raddr = move_src[ADDR_W-1:0];
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_STORE: begin
        ram_we    = cursor < CUR_W'(CELL_COUNT);
        ram_waddr = cursor[ADDR_W-1:0];
        ram_wdata = ch;
      end
      default: begin
      end
    endcase
  end

  tcsb_ram #(
    .WIDTH(8),
    .DEPTH(CELL_COUNT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      idx              <= '0;
      cursor_dir_cmd   <= RST_CURSOR_DIR;
      cursor_write_cmd <= RST_CURSOR_WRITE;
      memory_write_cmd <= RST_MEMORY_WRITE;
      cursor           <= '0;
      line             <= '0;
      col              <= '0;
      wstart           <= '0;
      wcount           <= '0;
      pending          <= 1'b0;
      pos              <= '0;
      rlen             <= '0;
      store_pend       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CURSOR_DIR:   cursor_dir_cmd   <= cfg_data;
          REG_CURSOR_WRITE: cursor_write_cmd <= cfg_data;
          REG_MEMORY_WRITE: memory_write_cmd <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (idx == CNT_W'(CELL_COUNT - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            if (operation == OP_CHAR) begin
              wstart <= start_eff;
              wcount <= last_of_write ? '0 : count_next;
              if (last_of_write) begin
                rlen    <= len_new;
                pos     <= '0;
                pending <= 1'b1;
              end
              priority if (char_code == CODE_CR) begin
                state <= S_IDLE;
              end else if (char_code == CODE_LF) begin
                if (line < LINE_W'(LINE_COUNT - 1)) begin
                  line   <= line + LINE_W'(1);
                  cursor <= cursor - CUR_W'(col) + CUR_W'(CHARS_PER_LINE);
                  col    <= '0;
                end else begin
                  cursor     <= CUR_W'(LAST_START);
                  line       <= LINE_W'(LINE_COUNT - 1);
                  col        <= '0;
                  store_pend <= 1'b0;
                  idx        <= scroll_idx;
                  state      <= scroll_state;
                end
              end else begin
                ch <= char_code;
                if (cursor >= CUR_W'(CELL_COUNT)) begin
                  // no room left: scroll, then store
                  cursor     <= CUR_W'(LAST_START);
                  line       <= LINE_W'(LINE_COUNT - 1);
                  col        <= '0;
                  store_pend <= 1'b1;
                  idx        <= scroll_idx;
                  state      <= scroll_state;
                end else begin
                  state <= S_STORE;
                end
              end
            end else if (pending) begin
              refresh_done <= seq_last;
              if (seq_last) begin
                pending <= 1'b0;
                pos     <= '0;
              end else begin
                pos <= pos + POS_W'(1);
              end
              if (pos < POS_W'(SEQ_HEAD)) begin
                lcd_is_command <= head_cmd;
                lcd_byte       <= head_byte;
              end else begin
                lcd_is_command <= 1'b0;
                state          <= S_READ;
              end
            end
          end
        end

        S_READ: begin
          lcd_byte <= ram_rdata;
          state    <= S_IDLE;
        end

        S_STORE: begin
          cursor <= cursor + CUR_W'(1);
          if (col == COL_W'(CHARS_PER_LINE - 1)) begin
            col  <= '0;
            line <= line + LINE_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
          state <= S_IDLE;
        end

        S_MOVE: begin
          if (idx == CNT_W'(MOVE_N)) begin
            if (HAS_FILL) begin
              idx   <= CNT_W'(FILL_LO);
              state <= S_FILL;
            end else begin
              state <= S_SCROLL_END;
            end
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        S_FILL: begin
          if (idx == CNT_W'(FILL_LAST)) begin
            state <= S_SCROLL_END;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        S_SCROLL_END: begin
          state <= store_pend ? S_STORE : S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // refresh position always inside the armed sequence
  `TCSB_ASSERT(a_pos_in_seq, pending |-> (pos_inc <= seq_end), "refresh position past sequence end")
  // a cell byte is always presented the cycle after the read state
  `TCSB_ASSERT(a_read_to_out, (state == S_READ) |=> out_valid, "cell byte not presented after read")
  // ram writes stay inside the grid
  `TCSB_ASSERT(a_waddr_range, ram_we |-> (ram_waddr < ADDR_W'(CELL_COUNT - 1) ||
                                          ram_waddr == ADDR_W'(CELL_COUNT - 1)),
               "grid write outside the cell range")
  // no item is taken while a scroll sweep runs
  `TCSB_NEVER(a_no_take_in_sweep, in_fire && (state == S_MOVE || state == S_FILL),
              "item taken during scroll")

endmodule

`default_nettype wire
